@@ hdl/buddy_page_allocator_defines.svh @@
// Assertion macros used by the checker file of the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Condition and consequence in the same cycle.
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bpa_pkg.sv @@
// Shared constants, codes and a helper function of the buddy page allocator.
package bpa_pkg;

    localparam int BPA_MAX_POOL_LOG2   = 10;
    localparam int BPA_RESET_POOL_LOG2 = 10;

    localparam int CMD_W      = 1;
    localparam int COUNT_W    = 11;
    localparam int PAGE_W     = 20;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;
    localparam int LOG2_W     = 4;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE_LOG2 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE_PAGE = 1'b1;

    // Exponent of the smallest power of two that is not below want; zero maps to zero.
    function automatic logic [LOG2_W-1:0] bpa_ceil_log2(input logic [COUNT_W-1:0] want);
        logic [LOG2_W-1:0] k;
        k = '0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (want > (COUNT_W'(1) << i)) begin
                k = LOG2_W'(i + 1);
            end
        end
        return k;
    endfunction

endpackage

@@ hdl/bpa_req_if.sv @@
// Request channel of the buddy page allocator.
interface bpa_req_if import bpa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [COUNT_W-1:0]   page_count;
    logic [PAGE_W-1:0]    free_page;

    modport source (output valid, output command, output page_count, output free_page,
                    input ready);
    modport sink   (input valid, input command, input page_count, input free_page,
                    output ready);
endinterface

@@ hdl/bpa_rsp_if.sv @@
// Response channel of the buddy page allocator.
interface bpa_rsp_if import bpa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PAGE_W-1:0]    granted_page;
    logic [COUNT_W-1:0]   block_pages;

    modport source (output valid, output status, output granted_page, output block_pages,
                    input ready);
    modport sink   (input valid, input status, input granted_page, input block_pages,
                    output ready);
endinterface

@@ hdl/bpa_tree_ram.sv @@
// Tree node memory: one write port and one read port with registered read data.
module bpa_tree_ram import bpa_pkg::*; #(
    parameter int ADDR_W = BPA_MAX_POOL_LOG2 + 1,
    parameter int DATA_W = BPA_MAX_POOL_LOG2 + 1,
    parameter int DEPTH  = (2 << BPA_MAX_POOL_LOG2) - 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/buddy_page_allocator.sv @@
// Buddy page allocator: serves one allocate or free word at a time over a binary tree kept
// in one memory whose nodes hold the largest free power-of-two block below them. An allocate
// reads the root, descends one level at a time to a node of the rounded size, marks it used
// and, unless that is the root, climbs back up rewriting every ancestor; each step waits on
// the single read port of the tree memory. A free reads upward from the leaf until it finds
// the used node, then rewrites every ancestor. A page outside the pool is answered right
// after the range check, an allocate without room after the root read, and a free of a page
// that is not allocated only after it has read up to the root. After reset and after every
// write of pool_size_log2 the tree is refilled by a sweep over its active nodes, during which
// no request word is taken; configuration writes are still taken.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int MAX_POOL_LOG2 = BPA_MAX_POOL_LOG2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bpa_req_if.sink               req,
    bpa_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Node indexes and node values share one width: the root may hold 2^MAX_POOL_LOG2.
    localparam int NW    = MAX_POOL_LOG2 + 1;
    localparam int VW    = MAX_POOL_LOG2 + 1;
    localparam int EW    = $clog2(MAX_POOL_LOG2 + 1);
    localparam int CW    = (NW > COUNT_W + 1) ? NW : COUNT_W + 1;
    localparam int NODES = (2 << MAX_POOL_LOG2) - 1;
    localparam int RESET_LOG2 = (MAX_POOL_LOG2 < BPA_RESET_POOL_LOG2) ?
                                MAX_POOL_LOG2 : BPA_RESET_POOL_LOG2;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_ROOT    = 3'd3;
    localparam logic [2:0] ST_DESC    = 3'd4;
    localparam logic [2:0] ST_FSEARCH = 3'd5;
    localparam logic [2:0] ST_CLIMB   = 3'd6;
    localparam logic [2:0] ST_FIN     = 3'd7;

    // Control registers.
    logic [2:0]           state_reg,   state_next;
    logic [EW-1:0]        log2_reg;
    logic [PAGE_W-1:0]    base_reg;
    logic [NW-1:0]        node_reg,    node_next;
    logic [VW-1:0]        val_reg,     val_next;
    logic [EW-1:0]        exp_reg,     exp_next;
    logic                 out_valid_reg;

    // Request and result registers.
    logic [CMD_W-1:0]     cmd_reg;
    logic [LOG2_W-1:0]    k_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [PAGE_W-1:0]    res_page_reg,   res_page_next;
    logic [COUNT_W-1:0]   res_pages_reg,  res_pages_next;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [PAGE_W-1:0]    out_page_reg;
    logic [COUNT_W-1:0]   out_pages_reg;

    // Memory ports.
    logic                 wr_en;
    logic [NW-1:0]        wr_addr;
    logic [VW-1:0]        wr_data;
    logic [NW-1:0]        rd_addr;
    logic [VW-1:0]        rd_data;

    // Datapath terms.
    logic                 req_fire;
    logic                 cfg_size_write;
    logic                 out_load;
    logic [EW-1:0]        cfg_log2;
    logic [VW-1:0]        size_v;
    logic [CW-1:0]        want_v;
    logic [CW-1:0]        node_val_v;
    logic                 size_match;
    logic [PAGE_W-1:0]    off_v;
    logic                 outside_v;
    logic [NW-1:0]        leaf_v;
    logic [NW-1:0]        parent_v;
    logic [NW-1:0]        chosen_v;
    logic [NW-1:0]        cand_v;
    logic [NW-1:0]        grant_off_v;
    logic [NW-1:0]        last_node_v;
    logic [VW-1:0]        sweep_v;
    logic [VW-1:0]        blk_v;
    logic [EW-1:0]        exp_inc_v;
    logic [VW-1:0]        par_size_v;
    logic [VW:0]          sum_v;
    logic [VW-1:0]        max_v;
    logic [VW-1:0]        merge_v;

    // Left children sit at odd indexes, so the buddy is one step away in either direction.
    function automatic logic [NW-1:0] sibling_of(input logic [NW-1:0] i);
        return i[0] ? i + NW'(1) : i - NW'(1);
    endfunction

    bpa_tree_ram #(
        .ADDR_W (NW),
        .DATA_W (VW),
        .DEPTH  (NODES)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_fire       = req.valid && req.ready;
    assign cfg_size_write = cfg_we && (cfg_index == CFG_POOL_SIZE_LOG2);
    assign cfg_log2       = (cfg_data[LOG2_W-1:0] > LOG2_W'(MAX_POOL_LOG2)) ?
                            EW'(MAX_POOL_LOG2) : EW'(cfg_data[LOG2_W-1:0]);

    assign size_v      = VW'(1) << log2_reg;
    assign want_v      = CW'(1) << k_reg;
    assign node_val_v  = CW'(rd_data);
    assign size_match  = (5'(k_reg) == 5'(exp_reg));

    // Range check of a free: the offset from the base must lie below the pool size.
    assign off_v       = page_reg - base_reg;
    assign outside_v   = (page_reg < base_reg) || ((off_v >> log2_reg) != '0);
    assign leaf_v      = NW'(off_v[MAX_POOL_LOG2-1:0]) + size_v - NW'(1);

    assign parent_v    = (node_reg - NW'(1)) >> 1;
    assign chosen_v    = (node_val_v >= want_v) ? node_reg : node_reg + NW'(1);
    assign cand_v      = (chosen_v << 1) + NW'(1);
    assign grant_off_v = ((chosen_v + NW'(1)) << exp_reg) - size_v;

    // The last active node is 2 * size - 2; at full size the doubling wraps and still lands.
    assign last_node_v = (size_v << 1) - NW'(2);

    // During the sweep the block size halves at every node that opens a new level.
    assign sweep_v     = ((node_reg != '0) && (((node_reg + NW'(1)) & node_reg) == '0)) ?
                         (val_reg >> 1) : val_reg;

    assign blk_v       = VW'(1) << exp_reg;
    assign exp_inc_v   = exp_reg + EW'(1);
    assign par_size_v  = VW'(1) << exp_inc_v;
    assign sum_v       = {1'b0, val_reg} + {1'b0, rd_data};
    assign max_v       = (rd_data > val_reg) ? rd_data : val_reg;

    // An allocate keeps the larger child; a free merges two wholly free buddies.
    assign merge_v     = ((cmd_reg == CMD_FREE) && (sum_v == {1'b0, par_size_v})) ?
                         par_size_v : max_v;

    assign out_load    = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        val_next        = val_reg;
        exp_next        = exp_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_pages_next  = res_pages_reg;
        wr_en           = 1'b0;
        wr_addr         = node_reg;
        wr_data         = '0;
        rd_addr         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_START;
                end
            end
            ST_INIT:
            begin
                wr_en     = 1'b1;
                wr_data   = sweep_v;
                val_next  = sweep_v;
                node_next = node_reg + NW'(1);
                if (node_reg == last_node_v)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                res_status_next = STATUS_OK;
                res_page_next   = '0;
                res_pages_next  = '0;
                if (cmd_reg == CMD_ALLOC)
                begin
                    exp_next   = log2_reg;
                    rd_addr    = '0;
                    state_next = ST_ROOT;
                end
                else if (outside_v)
                begin
                    res_status_next = STATUS_OUTSIDE;
                    state_next      = ST_FIN;
                end
                else
                begin
                    node_next  = leaf_v;
                    exp_next   = '0;
                    rd_addr    = leaf_v;
                    state_next = ST_FSEARCH;
                end
            end
            ST_ROOT:
            begin
                if (node_val_v < want_v)
                begin
                    res_status_next = STATUS_NO_ROOM;
                    state_next      = ST_FIN;
                end
                else if (size_match)
                begin
                    // The whole pool goes out as one block.
                    wr_en          = 1'b1;
                    wr_addr        = '0;
                    res_page_next  = base_reg;
                    res_pages_next = COUNT_W'(want_v);
                    state_next     = ST_FIN;
                end
                else
                begin
                    node_next  = NW'(1);
                    exp_next   = exp_reg - EW'(1);
                    rd_addr    = NW'(1);
                    state_next = ST_DESC;
                end
            end
            ST_DESC:
            begin
                if (size_match)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = chosen_v;
                    res_page_next  = base_reg + PAGE_W'(grant_off_v);
                    res_pages_next = COUNT_W'(want_v);
                    node_next      = chosen_v;
                    val_next       = '0;
                    rd_addr        = sibling_of(chosen_v);
                    state_next     = ST_CLIMB;
                end
                else
                begin
                    node_next = cand_v;
                    exp_next  = exp_reg - EW'(1);
                    rd_addr   = cand_v;
                end
            end
            ST_FSEARCH:
            begin
                if (rd_data != '0)
                begin
                    if (node_reg == '0)
                    begin
                        res_status_next = STATUS_NOT_ALLOC;
                        state_next      = ST_FIN;
                    end
                    else
                    begin
                        node_next = parent_v;
                        exp_next  = exp_inc_v;
                        rd_addr   = parent_v;
                    end
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = blk_v;
                    val_next       = blk_v;
                    res_pages_next = COUNT_W'(blk_v);
                    rd_addr        = sibling_of(node_reg);
                    state_next     = (node_reg == '0) ? ST_FIN : ST_CLIMB;
                end
            end
            ST_CLIMB:
            begin
                // The read data is the buddy of the node just written.
                wr_en     = 1'b1;
                wr_addr   = parent_v;
                wr_data   = merge_v;
                node_next = parent_v;
                val_next  = merge_v;
                exp_next  = exp_inc_v;
                rd_addr   = sibling_of(parent_v);
                if (parent_v == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new pool size restarts the tree fill from the root.
        if (cfg_size_write)
        begin
            state_next = ST_INIT;
            node_next  = '0;
            val_next   = VW'(1) << cfg_log2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            node_reg      <= '0;
            val_reg       <= VW'(1) << RESET_LOG2;
            exp_reg       <= '0;
            log2_reg      <= EW'(RESET_LOG2);
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            val_reg   <= val_next;
            exp_reg   <= exp_next;
            if (cfg_size_write)
            begin
                log2_reg <= cfg_log2;
            end
            if (cfg_we && (cfg_index == CFG_POOL_BASE_PAGE))
            begin
                base_reg <= cfg_data[PAGE_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            cmd_reg  <= req.command;
            k_reg    <= bpa_ceil_log2(req.page_count);
            page_reg <= req.free_page;
        end
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_pages_reg  <= res_pages_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
            out_pages_reg  <= res_pages_reg;
        end
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_page = out_page_reg;
    assign rsp.block_pages  = out_pages_reg;

endmodule

@@ hdl/bpa_checker.sv @@
// Port-level checker of the buddy page allocator and its binding to the top level.
`include "buddy_page_allocator_defines.svh"

module bpa_checker import bpa_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [STATUS_W-1:0]  rsp_status,
    input logic [PAGE_W-1:0]    rsp_granted_page,
    input logic [COUNT_W-1:0]   rsp_block_pages,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index
);

    `BPA_ASSERT_NEXT(a_one_word_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
    `BPA_ASSERT_NEXT(a_resize_refills, cfg_we && (cfg_index == CFG_POOL_SIZE_LOG2), !req_ready, "request taken during tree refill")
    `BPA_ASSERT_NOW(a_failure_is_empty, rsp_valid && (rsp_status != STATUS_OK), (rsp_granted_page == '0) && (rsp_block_pages == '0), "failed word carries a block")
    `BPA_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_page) && $stable(rsp_block_pages), "stalled response changed")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_granted_page (rsp.granted_page),
    .rsp_block_pages  (rsp.block_pages),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the buddy page allocator, with its own model of the free tree.
module tb_top;
    import bpa_pkg::*;

    localparam int TREE_NODES   = (2 << BPA_MAX_POOL_LOG2) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_COUNT  = 12;
    localparam int PHASE_ITEMS  = 77;

    // One request word as the sender presents it.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [COUNT_W-1:0] page_count;
        logic [PAGE_W-1:0]  free_page;
    } page_request_t;

    // One response word as the allocator should return it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   granted_page;
        logic [COUNT_W-1:0]  block_pages;
    } page_answer_t;

    // A block that the model believes is still allocated; frees are aimed at these.
    typedef struct {
        logic [PAGE_W-1:0] page;
        int unsigned       pages;
    } held_block_t;

    // Every block input starts at a known value; the channel signals are driven from these
    // variables through continuous assignments so that each has exactly one driver.
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = CFG_POOL_SIZE_LOG2;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  req_valid   = 1'b0;
    logic [CMD_W-1:0]      req_command = CMD_ALLOC;
    logic [COUNT_W-1:0]    req_count   = '0;
    logic [PAGE_W-1:0]     req_page    = '0;
    logic                  rsp_ready   = 1'b0;

    bpa_req_if req_if ();
    bpa_rsp_if rsp_if ();

    assign req_if.valid      = req_valid;
    assign req_if.command    = req_command;
    assign req_if.page_count = req_count;
    assign req_if.free_page  = req_page;
    assign rsp_if.ready      = rsp_ready;

    buddy_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The clock runs at 125 MHz.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Model state: largest free power-of-two span below each tree node, pool size and base.
    logic [COUNT_W-1:0] free_span [TREE_NODES];
    int unsigned        model_log2;
    logic [PAGE_W-1:0]  model_base;

    page_request_t request_q [$];      // words waiting for the driver
    page_answer_t  due_answers_q [$];  // predicted answers, oldest first
    held_block_t   held_q [$];         // blocks granted and not yet released

    int  n_queued    = 0;
    int  n_answered  = 0;
    int  n_allocs    = 0;
    int  pool_writes = 0;
    int  errors      = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  sender_idles    = 1'b1;
    bit  receiver_stalls = 1'b1;

    // A pool size write leaves every node of the active tree holding the size of its own subtree.
    function automatic void reset_free_spans();
        int unsigned pages;
        pages = 1 << model_log2;
        foreach (free_span[i])
        begin
            free_span[i] = '0;
        end
        for (int d = 0; d <= int'(model_log2); d++)
        begin
            for (int i = (1 << d) - 1; i < (2 << d) - 1; i++)
            begin
                free_span[i] = COUNT_W'(pages >> d);
            end
        end
    endfunction

    // Allocate: round up to a power of two, descend preferring the left child, mark the
    // chosen node used and refresh the ancestors with the larger of their children.
    function automatic page_answer_t predict_grant(logic [COUNT_W-1:0] want);
        int unsigned  need, pages, span, node, left, offset, lspan, rspan;
        page_answer_t answer;
        need  = 1;
        pages = 1 << model_log2;
        while (need < want)
        begin
            need = need << 1;
        end
        answer = '{STATUS_NO_ROOM, '0, '0};
        if (free_span[0] < need)
        begin
            return answer;
        end
        span = pages;
        node = 0;
        while (span != need)
        begin
            left = 2 * node + 1;
            node = (free_span[left] >= need) ? left : left + 1;
            span = span >> 1;
        end
        free_span[node] = '0;
        offset = (node + 1) * span - pages;
        while (node != 0)
        begin
            node  = (node - 1) / 2;
            lspan = free_span[2 * node + 1];
            rspan = free_span[2 * node + 2];
            free_span[node] = COUNT_W'(lspan > rspan ? lspan : rspan);
        end
        answer = '{STATUS_OK, PAGE_W'(model_base + offset), COUNT_W'(need)};
        return answer;
    endfunction

    // Free: climb from the leaf to the first used node, restore it, and merge buddies
    // on the way up where both halves are wholly free.
    function automatic page_answer_t predict_release(logic [PAGE_W-1:0] page);
        int unsigned       pages, node, span, freed, lspan, rspan;
        logic [PAGE_W-1:0] rel;
        page_answer_t      answer;
        pages  = 1 << model_log2;
        rel    = page - model_base;
        answer = '{STATUS_OUTSIDE, '0, '0};
        if (page < model_base || rel >= pages)
        begin
            return answer;
        end
        node = rel + pages - 1;
        span = 1;
        while (free_span[node] != 0)
        begin
            if (node == 0)
            begin
                answer.status = STATUS_NOT_ALLOC;
                return answer;
            end
            span = span << 1;
            node = (node - 1) / 2;
        end
        free_span[node] = COUNT_W'(span);
        freed = span;
        while (node != 0)
        begin
            node  = (node - 1) / 2;
            span  = span << 1;
            lspan = free_span[2 * node + 1];
            rspan = free_span[2 * node + 2];
            if (lspan + rspan == span)
            begin
                free_span[node] = COUNT_W'(span);
            end
            else
            begin
                free_span[node] = COUNT_W'(lspan > rspan ? lspan : rspan);
            end
        end
        answer = '{STATUS_OK, '0, COUNT_W'(freed)};
        return answer;
    endfunction

    function automatic void compare_field(string name, logic [PAGE_W-1:0] want,
                                          logic [PAGE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Driver. A word is predicted at the edge where it is accepted, so the model sees the
    // requests in the same order as the block. After each word the sender may hold off,
    // when sender_idles is set, before it offers the next one.
    page_request_t in_flight;
    page_answer_t  fresh_answer;
    logic          send_next;
    int unsigned   send_gap;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            send_next = req_valid;
            if (req_valid && req_if.ready)
            begin
                if (in_flight.command == CMD_ALLOC)
                begin
                    fresh_answer = predict_grant(in_flight.page_count);
                    if (fresh_answer.status == STATUS_OK)
                    begin
                        held_q.push_back('{fresh_answer.granted_page,
                                           int'(fresh_answer.block_pages)});
                    end
                end
                else
                begin
                    fresh_answer = predict_release(in_flight.free_page);
                    if (fresh_answer.status == STATUS_OK)
                    begin
                        for (int i = held_q.size() - 1; i >= 0; i--)
                        begin
                            if (held_q[i].page == in_flight.free_page)
                            begin
                                held_q.delete(i);
                            end
                        end
                    end
                end
                due_answers_q.push_back(fresh_answer);
                send_next = 1'b0;
                send_gap  = sender_idles ? $urandom_range(0, 3) : 0;
            end
            if (!send_next)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (request_q.size() > 0)
                begin
                    in_flight = request_q.pop_front();
                    req_command <= in_flight.command;
                    req_count   <= in_flight.page_count;
                    req_page    <= in_flight.free_page;
                    send_next = 1'b1;
                end
            end
            // Only one assignment per edge, so valid never drops between two back-to-back words.
            req_valid <= send_next;
        end
    end

    // Monitor. Each response word is checked field by field against the oldest prediction.
    // After each word the receiver may drop ready, when receiver_stalls is set.
    page_answer_t want_answer;
    logic         take_next;
    int unsigned  stall_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            take_next = rsp_ready;
            if (rsp_if.valid && rsp_ready)
            begin
                if (due_answers_q.size() == 0)
                begin
                    $display("%0t: response with nothing expected: status %0d page %0h pages %0d",
                             $time, rsp_if.status, rsp_if.granted_page, rsp_if.block_pages);
                    errors++;
                end
                else
                begin
                    want_answer = due_answers_q.pop_front();
                    compare_field("status", PAGE_W'(want_answer.status), PAGE_W'(rsp_if.status));
                    compare_field("granted_page", want_answer.granted_page,
                                  rsp_if.granted_page);
                    compare_field("block_pages", PAGE_W'(want_answer.block_pages),
                                  PAGE_W'(rsp_if.block_pages));
                    n_answered++;
                end
                status_seen[rsp_if.status]++;
                stall_left = receiver_stalls ? $urandom_range(0, 3) : 0;
                take_next  = (stall_left == 0);
            end
            else if (!take_next)
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                end
                if (stall_left == 0)
                begin
                    take_next = 1'b1;
                end
            end
            rsp_ready <= take_next;
        end
    end

    // The generator keeps only a couple of words ahead of the driver, so that frees can be
    // aimed at blocks that the model has just granted.
    task automatic queue_req(logic [CMD_W-1:0] command, logic [COUNT_W-1:0] count,
                             logic [PAGE_W-1:0] page);
        while (request_q.size() >= 2)
        begin
            @(posedge clk);
        end
        request_q.push_back('{command, count, page});
        n_queued++;
        if (command == CMD_ALLOC)
        begin
            n_allocs++;
        end
    endtask

    // Wait until every word sent has been answered, then give the block some spare cycles.
    task automatic settle(int unsigned extra);
        while (n_answered != n_queued)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == CFG_POOL_SIZE_LOG2)
        begin
            // Sizes above the largest tree saturate, and the tree starts over all free.
            model_log2 = (value[LOG2_W-1:0] > BPA_MAX_POOL_LOG2) ? BPA_MAX_POOL_LOG2
                                                                 : value[LOG2_W-1:0];
            reset_free_spans();
            pool_writes++;
        end
        else
        begin
            model_base = value;
        end
        held_q.delete();
    endtask

    // The block must be idle before its registers change. The upper bits of the size word
    // carry random junk, which the block must ignore.
    task automatic set_pool(int unsigned log2, logic [PAGE_W-1:0] base);
        settle(DRAIN_CYCLES);
        write_reg(CFG_POOL_SIZE_LOG2, {(CFG_DATA_W - LOG2_W)'($urandom), LOG2_W'(log2)});
        write_reg(CFG_POOL_BASE_PAGE, base);
    endtask

    initial
    begin
        int unsigned       pages;
        int unsigned       sel;
        int unsigned       log2;
        held_block_t       target;
        logic [COUNT_W-1:0] count;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] base;

        model_log2 = BPA_RESET_POOL_LOG2;
        model_base = '0;
        reset_free_spans();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset pool of 1024 pages at base 0. A zero count is one page;
        // a count of 3 rounds to 4; the whole pool and an out-of-range count fail for room
        // once the tree is fragmented.
        queue_req(CMD_ALLOC, 11'd0, '0);
        queue_req(CMD_ALLOC, 11'd1, '1);
        queue_req(CMD_ALLOC, 11'd3, '0);
        queue_req(CMD_ALLOC, 11'd1024, '0);
        queue_req(CMD_ALLOC, 11'd2047, '0);
        // Freeing a page twice is refused the second time; a page inside a used block
        // releases the whole block.
        queue_req(CMD_FREE, '1, 20'd0);
        queue_req(CMD_FREE, '0, 20'd0);
        queue_req(CMD_FREE, '0, 20'd6);
        queue_req(CMD_FREE, '0, 20'd1);
        // Pages past the end of the pool, including the highest page number.
        queue_req(CMD_FREE, '0, 20'd1024);
        queue_req(CMD_FREE, '0, '1);
        // With everything merged back, the whole pool can be taken and returned.
        queue_req(CMD_ALLOC, 11'd1024, '0);
        queue_req(CMD_ALLOC, 11'd0, '0);
        queue_req(CMD_FREE, '0, 20'd512);
        queue_req(CMD_ALLOC, 11'd513, '0);
        queue_req(CMD_FREE, '0, 20'd0);

        // An oversized pool size saturates; a high base makes granted pages wrap around,
        // and a wrapped page then lies below the base.
        set_pool(15, 20'hFFF00);
        queue_req(CMD_ALLOC, 11'd512, '0);
        queue_req(CMD_ALLOC, 11'd256, '0);
        queue_req(CMD_FREE, '0, 20'h00100);
        queue_req(CMD_FREE, '0, 20'hFFEFF);
        queue_req(CMD_FREE, '0, 20'hFFF00);

        // A pool of a single page.
        set_pool(0, 20'h12345);
        queue_req(CMD_ALLOC, 11'd0, '0);
        queue_req(CMD_ALLOC, 11'd2, '0);
        queue_req(CMD_FREE, '0, 20'h12346);
        queue_req(CMD_FREE, '0, 20'h12345);
        queue_req(CMD_FREE, '0, 20'h12345);

        // Random phases, each on its own pool size and base. Most frees target blocks the
        // model holds as granted; the rest are stray pages in, below and beyond the pool.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0:
                begin
                    log2 = BPA_MAX_POOL_LOG2;
                    base = '0;
                end
                1:
                begin
                    log2 = 0;
                    base = '1;
                end
                2:
                begin
                    log2 = 15;
                    base = 20'hFFC00;
                end
                3:
                begin
                    log2 = $urandom_range(BPA_MAX_POOL_LOG2 + 1, 15);
                    base = PAGE_W'($urandom);
                end
                default:
                begin
                    log2 = $urandom_range(1, BPA_MAX_POOL_LOG2);
                    base = PAGE_W'($urandom);
                end
            endcase
            set_pool(log2, base);
            // Some phases run without any idle cycles on one side or both.
            sender_idles    = (ph % 3 != 2);
            receiver_stalls = (ph % 4 != 3);
            pages = 1 << model_log2;

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Halfway through, the sender holds back until every answer is in.
                if (i == PHASE_ITEMS / 2)
                begin
                    settle(0);
                end
                sel   = $urandom_range(0, 99);
                count = COUNT_W'($urandom);
                page  = PAGE_W'($urandom);
                if (sel < 45)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5:
                            count = COUNT_W'($urandom_range(0, pages < 4 ? pages : 4));
                        6, 7:             count = COUNT_W'($urandom_range(0, pages));
                        8:                count = COUNT_W'($urandom_range(pages, 1024));
                        default:          count = COUNT_W'($urandom);
                    endcase
                    queue_req(CMD_ALLOC, count, page);
                end
                else if (sel < 85 && held_q.size() > 0)
                begin
                    target = held_q[$urandom_range(0, held_q.size() - 1)];
                    page   = target.page;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        page = target.page + PAGE_W'($urandom_range(0, target.pages - 1));
                    end
                    queue_req(CMD_FREE, count, page);
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       page = model_base + PAGE_W'($urandom_range(0, pages - 1));
                        1:       page = model_base - PAGE_W'($urandom_range(1, 4));
                        2:       page = model_base + PAGE_W'(pages + $urandom_range(0, 3));
                        default: page = PAGE_W'($urandom);
                    endcase
                    queue_req(CMD_FREE, count, page);
                end
            end
        end

        settle(DRAIN_CYCLES);
        if (due_answers_q.size() != 0)
        begin
            $display("%0t: %0d predicted responses never arrived", $time, due_answers_q.size());
            errors += due_answers_q.size();
        end
        $display("Sent %0d requests (%0d allocates, %0d frees) over %0d pool settings.",
                 n_queued, n_allocs, n_queued - n_allocs, pool_writes);
        $display("Responses: %0d ok, %0d no room, %0d not allocated, %0d outside pool.",
                 status_seen[STATUS_OK], status_seen[STATUS_NO_ROOM],
                 status_seen[STATUS_NOT_ALLOC], status_seen[STATUS_OUTSIDE]);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial
    begin
        #20_000_000;
        $display("%0t: timeout with %0d of %0d responses in", $time, n_answered, n_queued);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_req_if.sv
hdl/bpa_rsp_if.sv
hdl/bpa_tree_ram.sv
hdl/buddy_page_allocator.sv
hdl/bpa_checker.sv
dv/tb_top.sv
